// File: rtl/gks_pkg.sv
`default_nettype none

package gks_pkg;

  // item operation codes
  typedef enum logic [1:0] {
    OP_START    = 2'd0,
    OP_ADD      = 2'd1,
    OP_SUPPRESS = 2'd2,
    OP_FETCH    = 2'd3
  } op_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_RADIUS = 2'd0,
    REG_BORDER = 2'd1,
    REG_WIDTH  = 2'd2,
    REG_HEIGHT = 2'd3
  } reg_e;

  // cell mark codes
  localparam logic [1:0] MARK_EMPTY = 2'd0;
  localparam logic [1:0] MARK_SET   = 2'd1;
  localparam logic [1:0] MARK_KEPT  = 2'd2;

  localparam int COL_W   = 9;
  localparam int ROW_W   = 8;
  localparam int INDEX_W = 12;
  localparam int CFG_W   = 9;

  // back end sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SUP_RD,
    ST_SUP_CTR,
    ST_SUP_CHK,
    ST_SUP_WIN,
    ST_SUP_KEEP,
    ST_F_STEP,
    ST_F_WAIT,
    ST_RESULT
  } back_state_e;

  typedef struct packed {
    op_e              op;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } cmd_t;

  typedef struct packed {
    logic [2:0]       radius;
    logic [4:0]       border;
    logic [COL_W-1:0] fwidth;
    logic [ROW_W-1:0] fheight;
  } cfg_t;

  typedef struct packed {
    logic               dropped;
    logic               fin;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic [INDEX_W-1:0] idx;
    logic               found;
  } res_t;

endpackage

`default_nettype wire

// File: rtl/grid_keypoint_suppression_top.sv
`default_nettype none

// Grid non-maximum suppression of keypoints. Words on the slave side carry an
// operation in tuser (start, add, suppress, fetch); only fetch returns a word.
// After reset and after every start all MAX_WIDTH*MAX_HEIGHT cells of the
// occupancy grid (76800 at the defaults) are cleared one cell a cycle; no word
// is taken during the clearing pass after reset. A suppress steps through the
// read, centre and check states for each stored point and, for each point that
// is kept, visits every cell of the clipped (2*radius+1) square and then marks
// it kept, as every grid write goes through the single mark memory port. A
// fetch walks the grid in raster order, skipping border cells and reading each
// interior cell, until the kept point and the one after it are seen.
// A two word command queue and an output register let both sides stall.
module grid_keypoint_suppression_top
  import gks_pkg::*;
#(
  parameter int MAX_WIDTH  = 320,
  parameter int MAX_HEIGHT = 240,
  parameter int MAX_POINTS = 4096,
  parameter int MAX_RADIUS = 7
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire logic [23:0]      s_axis_tdata,  // column, row
  input  wire logic [1:0]       s_axis_tuser,  // operation
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output logic [31:0]           m_axis_tdata,  // found, point_index, kept_column,
                                               // kept_row, dropped_any
  output logic                  m_axis_tlast,  // final_point
  input  wire logic             cfg_we_i,
  input  wire logic [1:0]       cfg_addr_i,
  input  wire logic [CFG_W-1:0] cfg_wdata_i
);

  cfg_t cfg_q;
  logic q_valid, q_pop, init_busy;
  cmd_t q_cmd;
  res_t res;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.radius  <= 3'd5;
      cfg_q.border  <= 5'd5;
      cfg_q.fwidth  <= 9'd320;
      cfg_q.fheight <= 8'd240;
    end else if (cfg_we_i) begin
      case (reg_e'(cfg_addr_i))
        REG_RADIUS: cfg_q.radius  <= cfg_wdata_i[2:0];
        REG_BORDER: cfg_q.border  <= cfg_wdata_i[4:0];
        REG_WIDTH:  cfg_q.fwidth  <= cfg_wdata_i[COL_W-1:0];
        REG_HEIGHT: cfg_q.fheight <= cfg_wdata_i[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  gks_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .op_i        (s_axis_tuser),
    .col_i       (s_axis_tdata[COL_W-1:0]),
    .row_i       (s_axis_tdata[COL_W+ROW_W-1:COL_W]),
    .init_busy_i (init_busy),
    .q_valid_o   (q_valid),
    .q_cmd_o     (q_cmd),
    .q_pop_i     (q_pop)
  );

  gks_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_POINTS (MAX_POINTS),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_cmd_i     (q_cmd),
    .q_pop_o     (q_pop),
    .cfg_i       (cfg_q),
    .init_busy_o (init_busy),
    .m_ready_i   (m_axis_tready),
    .m_valid_o   (m_axis_tvalid),
    .res_o       (res)
  );

  // pack the result word
  assign m_axis_tdata = {1'b0, res.dropped, res.row, res.col, res.idx, res.found};
  assign m_axis_tlast = res.fin;

`ifndef SYNTHESIS
  // an exhausted scan is always the final word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tlast)
    else $error("empty fetch result not marked final");

  // an exhausted scan carries no point
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[29:1] == 29'd0)
    else $error("empty fetch result carries point data");

  // nothing is taken while the grid clears after reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    init_busy |-> !m_axis_tvalid && !s_axis_tready)
    else $error("activity during reset clearing pass");
`endif

endmodule

`default_nettype wire

// File: rtl/gks_front.sv
`default_nettype none

module gks_front
  import gks_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_valid_i,
  output logic                  s_ready_o,
  input  wire logic [1:0]       op_i,
  input  wire logic [COL_W-1:0] col_i,
  input  wire logic [ROW_W-1:0] row_i,
  input  wire logic             init_busy_i,
  output logic                  q_valid_o,
  output cmd_t                  q_cmd_o,
  input  wire logic             q_pop_i
);

  cmd_t       buf_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q, cnt_d;
  logic       push;
  cmd_t       cmd;

  // classify the incoming word
  always_comb begin
    cmd.op  = op_e'(op_i);
    cmd.col = col_i;
    cmd.row = row_i;
  end

  assign s_ready_o = (cnt_q != 2'd2) && !init_busy_i;
  assign push      = s_valid_i && s_ready_o;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_cmd_o   = buf_q[rp_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !(q_pop_i && q_valid_o)) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push && q_pop_i && q_valid_o) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  // two entry command queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wp_q <= ~wp_q;
      end
      if (q_pop_i && q_valid_o) begin
        rp_q <= ~rp_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wp_q] <= cmd;
    end
  end

endmodule

`default_nettype wire

// File: rtl/gks_back.sv
`default_nettype none

module gks_back
  import gks_pkg::*;
#(
  parameter int MAX_WIDTH  = 320,
  parameter int MAX_HEIGHT = 240,
  parameter int MAX_POINTS = 4096,
  parameter int MAX_RADIUS = 7
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic q_valid_i,
  input  wire cmd_t q_cmd_i,
  output logic      q_pop_o,
  input  wire cfg_t cfg_i,
  output logic      init_busy_o,
  input  wire logic m_ready_i,
  output logic      m_valid_o,
  output res_t      res_o
);

  localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(CELLS);
  localparam int IW    = $clog2(MAX_POINTS);
  localparam int DW    = $clog2((MAX_WIDTH > MAX_HEIGHT ? MAX_WIDTH : MAX_HEIGHT)
                                + 2 * MAX_RADIUS + 512);
  localparam int SW    = COL_W + ROW_W;

  // memories
  logic [1:0]    marks_mem [CELLS];
  logic [IW-1:0] owner_mem [CELLS];
  logic [SW-1:0] store_mem [MAX_POINTS];

  logic          marks_we, marks_re, st_we, st_re, owner_we;
  logic [AW-1:0] marks_waddr, marks_raddr;
  logic [1:0]    marks_wdata, marks_rdata;
  logic [IW-1:0] owner_rdata, st_waddr, st_raddr;
  logic [SW-1:0] st_wdata, st_rdata;

  back_state_e state_q, state_d;
  logic          init_q;
  logic [IW:0]   count_q;
  logic          drop_q;
  logic [DW-1:0] scan_r_q, scan_c_q;
  logic [AW-1:0] clr_q;
  logic          mv_q;

  logic [IW-1:0] idx_q;
  logic [DW-1:0] pr_q, pc_q, rend_q, cend_q, c0_q, rr_q, cc_q;
  logic [AW-1:0] ctr_q;
  logic [DW-1:0] sr_q, sc_q, a_r_q, a_c_q;
  logic          phb_q, fnd_q, fin_q;
  logic [IW-1:0] own_q;
  res_t          res_q;

  // effective frame, border and radius
  logic [DW-1:0] uw, uh, rad, bd, bd2;
  logic          bad;
  always_comb begin
    uw  = (DW'(cfg_i.fwidth) > DW'(MAX_WIDTH)) ? DW'(MAX_WIDTH) : DW'(cfg_i.fwidth);
    uh  = (DW'(cfg_i.fheight) > DW'(MAX_HEIGHT)) ? DW'(MAX_HEIGHT) : DW'(cfg_i.fheight);
    rad = (DW'(cfg_i.radius) > DW'(MAX_RADIUS)) ? DW'(MAX_RADIUS) : DW'(cfg_i.radius);
    bd  = DW'(cfg_i.border);
    bd2 = bd << 1;
    bad = (bd2 >= uw) || (bd2 >= uh);
  end

  // add point decode
  logic          add_ok;
  logic [AW-1:0] add_addr;
  assign add_ok   = (DW'(q_cmd_i.col) < uw) && (DW'(q_cmd_i.row) < uh)
                    && (count_q < (IW+1)'(MAX_POINTS));
  assign add_addr = AW'(DW'(q_cmd_i.row) * MAX_WIDTH + DW'(q_cmd_i.col));

  // suppression window
  logic [DW-1:0] st_col, st_row, r0, c0, rlim, clim, rend, cend;
  logic          win_empty, win_centre, last_pt;
  logic [AW-1:0] ctr_addr, win_addr;
  always_comb begin
    st_col     = DW'(st_rdata[COL_W-1:0]);
    st_row     = DW'(st_rdata[SW-1:COL_W]);
    ctr_addr   = AW'(st_row * MAX_WIDTH + st_col);
    r0         = (pr_q > rad) ? pr_q - rad : '0;
    c0         = (pc_q > rad) ? pc_q - rad : '0;
    rlim       = pr_q + rad;
    clim       = pc_q + rad;
    rend       = (rlim > uh - DW'(1)) ? uh - DW'(1) : rlim;
    cend       = (clim > uw - DW'(1)) ? uw - DW'(1) : clim;
    win_empty  = (r0 >= uh) || (c0 >= uw);
    win_centre = (rr_q == pr_q) && (cc_q == pc_q);
    win_addr   = AW'(rr_q * MAX_WIDTH + cc_q);
    last_pt    = ((IW+1)'(idx_q) + (IW+1)'(1) == count_q);
  end

  // raster scan step
  logic          f_end, f_skip;
  logic [AW-1:0] f_addr;
  logic [DW-1:0] sr_nx, sc_nx;
  always_comb begin
    f_end  = bad || (sr_q >= uh - bd);
    f_skip = (sr_q < bd) || (sc_q < bd) || (sc_q >= uw - bd);
    f_addr = AW'(sr_q * MAX_WIDTH + sc_q);
    if (sc_q == DW'(MAX_WIDTH - 1)) begin
      sc_nx = '0;
      sr_nx = sr_q + DW'(1);
    end else begin
      sc_nx = sc_q + DW'(1);
      sr_nx = sr_q;
    end
  end

  logic out_free;
  assign out_free = !mv_q || m_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == AW'(CELLS - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (q_valid_i) begin
          case (q_cmd_i.op)
            OP_START:    state_d = ST_CLEAR;
            OP_SUPPRESS: state_d = (count_q == '0) ? ST_IDLE : ST_SUP_RD;
            OP_FETCH:    state_d = ST_F_STEP;
            default:     state_d = ST_IDLE;
          endcase
        end
      end
      ST_SUP_RD:  state_d = ST_SUP_CTR;
      ST_SUP_CTR: state_d = ST_SUP_CHK;
      ST_SUP_CHK: begin
        if (marks_rdata == MARK_SET) begin
          state_d = win_empty ? ST_SUP_KEEP : ST_SUP_WIN;
        end else begin
          state_d = last_pt ? ST_IDLE : ST_SUP_RD;
        end
      end
      ST_SUP_WIN: begin
        if (cc_q == cend_q && rr_q == rend_q) state_d = ST_SUP_KEEP;
      end
      ST_SUP_KEEP: state_d = last_pt ? ST_IDLE : ST_SUP_RD;
      ST_F_STEP: begin
        if (f_end) begin
          state_d = ST_RESULT;
        end else if (!f_skip) begin
          state_d = ST_F_WAIT;
        end
      end
      ST_F_WAIT: begin
        state_d = (marks_rdata == MARK_KEPT && phb_q) ? ST_RESULT : ST_F_STEP;
      end
      ST_RESULT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // memory controls and queue pop
  always_comb begin
    q_pop_o     = 1'b0;
    marks_we    = 1'b0;
    marks_waddr = '0;
    marks_wdata = MARK_EMPTY;
    owner_we    = 1'b0;
    st_we       = 1'b0;
    st_waddr    = IW'(count_q);
    st_wdata    = {q_cmd_i.row, q_cmd_i.col};
    marks_re    = 1'b0;
    marks_raddr = f_addr;
    st_re       = 1'b0;
    st_raddr    = idx_q;
    case (state_q)
      ST_CLEAR: begin
        marks_we    = 1'b1;
        marks_waddr = clr_q;
      end
      ST_IDLE: begin
        q_pop_o = q_valid_i;
        if (q_valid_i && q_cmd_i.op == OP_ADD && add_ok) begin
          marks_we    = 1'b1;
          marks_waddr = add_addr;
          marks_wdata = MARK_SET;
          owner_we    = 1'b1;
          st_we       = 1'b1;
        end
      end
      ST_SUP_RD: st_re = 1'b1;
      ST_SUP_CTR: begin
        marks_re    = 1'b1;
        marks_raddr = ctr_addr;
      end
      ST_SUP_WIN: begin
        marks_we    = !win_centre;
        marks_waddr = win_addr;
      end
      ST_SUP_KEEP: begin
        marks_we    = 1'b1;
        marks_waddr = ctr_q;
        marks_wdata = MARK_KEPT;
      end
      ST_F_STEP: marks_re = !f_end && !f_skip;
      default: ;
    endcase
  end

  // memory ports
  always_ff @(posedge clk_i) begin
    if (marks_we) marks_mem[marks_waddr] <= marks_wdata;
    if (owner_we) owner_mem[marks_waddr] <= IW'(count_q);
    if (marks_re) begin
      marks_rdata <= marks_mem[marks_raddr];
      owner_rdata <= owner_mem[marks_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_we) store_mem[st_waddr] <= st_wdata;
    if (st_re) st_rdata <= store_mem[st_raddr];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      init_q   <= 1'b1;
      count_q  <= '0;
      drop_q   <= 1'b0;
      scan_r_q <= '0;
      scan_c_q <= '0;
      clr_q    <= '0;
      mv_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (mv_q && m_ready_i && state_q != ST_RESULT) mv_q <= 1'b0;
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == AW'(CELLS - 1)) init_q <= 1'b0;
        end
        ST_IDLE: begin
          if (q_valid_i) begin
            case (q_cmd_i.op)
              OP_START: begin
                count_q  <= '0;
                drop_q   <= 1'b0;
                scan_r_q <= '0;
                scan_c_q <= '0;
                clr_q    <= '0;
              end
              OP_ADD: begin
                if (add_ok) begin
                  count_q <= count_q + (IW+1)'(1);
                end else begin
                  drop_q <= 1'b1;
                end
              end
              OP_SUPPRESS: begin
                scan_r_q <= '0;
                scan_c_q <= '0;
              end
              default: ;
            endcase
          end
        end
        ST_F_STEP: begin
          if (f_end && !phb_q) begin
            scan_r_q <= DW'(MAX_HEIGHT);
            scan_c_q <= '0;
          end
        end
        ST_F_WAIT: begin
          if (marks_rdata == MARK_KEPT && !phb_q) begin
            scan_r_q <= sr_nx;
            scan_c_q <= sc_nx;
          end
        end
        ST_RESULT: begin
          if (out_free) mv_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        idx_q <= '0;
        sr_q  <= scan_r_q;
        sc_q  <= scan_c_q;
        phb_q <= 1'b0;
      end
      ST_SUP_CTR: begin
        pr_q  <= st_row;
        pc_q  <= st_col;
        ctr_q <= ctr_addr;
      end
      ST_SUP_CHK: begin
        rr_q   <= r0;
        cc_q   <= c0;
        c0_q   <= c0;
        rend_q <= rend;
        cend_q <= cend;
        if (marks_rdata != MARK_SET) idx_q <= idx_q + IW'(1);
      end
      ST_SUP_WIN: begin
        if (cc_q == cend_q) begin
          cc_q <= c0_q;
          rr_q <= rr_q + DW'(1);
        end else begin
          cc_q <= cc_q + DW'(1);
        end
      end
      ST_SUP_KEEP: idx_q <= idx_q + IW'(1);
      ST_F_STEP: begin
        if (f_end) begin
          fin_q <= 1'b1;
          if (!phb_q) fnd_q <= 1'b0;
        end else if (f_skip) begin
          sr_q <= sr_nx;
          sc_q <= sc_nx;
        end
      end
      ST_F_WAIT: begin
        sr_q <= sr_nx;
        sc_q <= sc_nx;
        if (marks_rdata == MARK_KEPT) begin
          if (!phb_q) begin
            a_r_q <= sr_q;
            a_c_q <= sc_q;
            own_q <= owner_rdata;
            fnd_q <= 1'b1;
            phb_q <= 1'b1;
          end else begin
            fin_q <= 1'b0;
          end
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          res_q.found   <= fnd_q;
          res_q.idx     <= fnd_q ? INDEX_W'(own_q) : '0;
          res_q.col     <= fnd_q ? COL_W'(a_c_q) : '0;
          res_q.row     <= fnd_q ? ROW_W'(a_r_q) : '0;
          res_q.fin     <= fin_q;
          res_q.dropped <= drop_q;
        end
      end
      default: ;
    endcase
  end

  assign init_busy_o = init_q;
  assign m_valid_o   = mv_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire
